/* sv/assert_macros.svh */
// Assertion helpers, clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DTIQ_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DTIQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dtiq_pkg.sv */
package dtiq_pkg;

  localparam int NumChannels = 8;
  localparam int CountW      = 16;
  localparam int LevelW      = 8;
  localparam int TimeW       = 16;
  localparam int HoldW       = 8;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;

  localparam int OnTimeRst    = 20;
  localparam int OffTimeRst   = 20;
  localparam int HoldoffRst   = 30;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ON_TIME    = 2'd0,
    REG_OFF_TIME   = 2'd1,
    REG_ACTIVE_LOW = 2'd2,
    REG_HOLDOFF    = 2'd3
  } cfg_reg_e;

  // What one lane reports for the tick it is evaluating.
  typedef struct packed {
    logic state;
    logic changed;
  } lane_out_t;

  // One result item.
  typedef struct packed {
    logic [LevelW-1:0] states;
    logic [LevelW-1:0] trig;
    logic              hold;
  } result_t;

endpackage

/* sv/dtiq_lane.sv */
// One channel: on/off qualification counters and qualified state.
module dtiq_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          active,
  input  logic [dtiq_pkg::CountW-1:0]   on_time,
  input  logic [dtiq_pkg::CountW-1:0]   off_time,
  output dtiq_pkg::lane_out_t           lane_out
);

  logic                        state;
  logic                        state_next;
  logic [dtiq_pkg::CountW-1:0] on_cnt;
  logic [dtiq_pkg::CountW-1:0] on_cnt_next;
  logic [dtiq_pkg::CountW-1:0] off_cnt;
  logic [dtiq_pkg::CountW-1:0] off_cnt_next;
  logic [dtiq_pkg::CountW-1:0] on_inc;
  logic [dtiq_pkg::CountW-1:0] off_inc;

  assign on_inc  = on_cnt + dtiq_pkg::CountW'(1);
  assign off_inc = off_cnt + dtiq_pkg::CountW'(1);

  always_comb begin
    state_next   = state;
    on_cnt_next  = on_cnt;
    off_cnt_next = off_cnt;
    if (!state) begin
      if (active) begin
        // saturates at threshold; zero threshold never fires
        if (on_cnt < on_time) begin
          on_cnt_next = on_inc;
          if (on_inc == on_time) state_next = 1'b1;
        end
      end else begin
        on_cnt_next = '0;
      end
    end else begin
      if (!active) begin
        if (off_cnt < off_time) begin
          off_cnt_next = off_inc;
          if (off_inc == off_time) state_next = 1'b0;
        end
      end else begin
        off_cnt_next = '0;
      end
    end
    if (state_next != state) begin
      if (state_next) off_cnt_next = '0;
      else            on_cnt_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= 1'b0;
      on_cnt  <= '0;
      off_cnt <= '0;
    end else if (adv) begin
      state   <= state_next;
      on_cnt  <= on_cnt_next;
      off_cnt <= off_cnt_next;
    end
  end

  assign lane_out.state   = state_next;
  assign lane_out.changed = state_next ^ state;

endmodule

/* sv/dtiq_out_buf.sv */
// Two-entry result queue: head drives the output, skid catches a push
// while the head is stalled.
module dtiq_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dtiq_pkg::result_t push_data,
  output logic              can_push,
  output logic              head_valid,
  output dtiq_pkg::result_t head,
  input  logic              pop_ready
);

  dtiq_pkg::result_t skid;
  logic              skid_valid;
  logic              pop;

  assign pop      = head_valid && pop_ready;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (pop && skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else if (pop) begin
        head_valid <= push;
      end else if (push && head_valid) begin
        skid_valid <= 1'b1;
      end else if (push) begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (pop && skid_valid) begin
      head <= skid;
    end else if (push && (pop || !head_valid)) begin
      head <= push_data;
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

/* sv/dual_time_input_qualifier.sv */
// Dual-time input qualifier. Each accepted request is one tick holding the raw
// pin level of every channel. After the optional active-low inversion, each
// channel must see the opposite level for on_time consecutive ticks to turn
// on, or off_time ticks to turn off; a threshold of zero blocks that direction
// and a level that falls back restarts the count. A state change raises that
// channel's trigger flag for the tick, masked while the start-up hold-off
// counter (loaded with HoldoffRst at reset and with cfg_data on every write of
// REG_HOLDOFF) is still nonzero. Rate: one request per clock while in_ready is
// high; every channel has its own lane and all lanes evaluate the tick in
// the same cycle, and the result is registered at acceptance. A two-entry
// result queue keeps in_ready high while one finished result waits on
// out_ready; in_ready drops only when two results are pending.
// Configuration writes take effect at the edge where cfg_we is high and are
// meant to happen only while no request is in flight.
module dual_time_input_qualifier (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [dtiq_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [dtiq_pkg::CfgDataW-1:0]   cfg_data,
  // tick input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dtiq_pkg::LevelW-1:0]     raw_levels,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dtiq_pkg::LevelW-1:0]     qualified_states,
  output logic [dtiq_pkg::LevelW-1:0]     trigger_flags,
  output logic                            holdoff_active
);

  // Configuration registers
  logic [dtiq_pkg::CountW-1:0]      on_time;
  logic [dtiq_pkg::CountW-1:0]      off_time;
  logic                             active_low;
  logic [dtiq_pkg::HoldW-1:0]       holdoff_count;

  logic                             accept;
  logic [dtiq_pkg::NumChannels-1:0] level_vec;
  logic [dtiq_pkg::NumChannels-1:0] active_vec;
  logic [dtiq_pkg::NumChannels-1:0] state_vec;
  logic [dtiq_pkg::NumChannels-1:0] change_vec;
  logic                             hold;
  dtiq_pkg::lane_out_t              lane_out [dtiq_pkg::NumChannels];
  dtiq_pkg::result_t                result;
  dtiq_pkg::result_t                head;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_time    <= dtiq_pkg::CountW'(dtiq_pkg::OnTimeRst);
      off_time   <= dtiq_pkg::CountW'(dtiq_pkg::OffTimeRst);
      active_low <= 1'b1;
    end else if (cfg_we) begin
      unique case (dtiq_pkg::cfg_reg_e'(cfg_index))
        dtiq_pkg::REG_ON_TIME:
          on_time <= dtiq_pkg::CountW'(cfg_data[dtiq_pkg::TimeW-1:0]);
        dtiq_pkg::REG_OFF_TIME:
          off_time <= dtiq_pkg::CountW'(cfg_data[dtiq_pkg::TimeW-1:0]);
        dtiq_pkg::REG_ACTIVE_LOW:
          active_low <= cfg_data[0];
        dtiq_pkg::REG_HOLDOFF: ;  // handled with the hold-off counter
        default: ;
      endcase
    end
  end

  // Hold-off: reloaded by a write, counts ticks down to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff_count <= dtiq_pkg::HoldW'(dtiq_pkg::HoldoffRst);
    end else if (cfg_we && dtiq_pkg::cfg_reg_e'(cfg_index) == dtiq_pkg::REG_HOLDOFF) begin
      holdoff_count <= cfg_data[dtiq_pkg::HoldW-1:0];
    end else if (accept && hold) begin
      holdoff_count <= holdoff_count - dtiq_pkg::HoldW'(1);
    end
  end

  assign hold = (holdoff_count != '0);

  // Channels beyond the input width see level 0.
  assign level_vec  = dtiq_pkg::NumChannels'(raw_levels);
  assign active_vec = level_vec ^ {dtiq_pkg::NumChannels{active_low}};

  for (genvar i = 0; i < dtiq_pkg::NumChannels; i++) begin : g_lane
    dtiq_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .adv      (accept),
      .active   (active_vec[i]),
      .on_time  (on_time),
      .off_time (off_time),
      .lane_out (lane_out[i])
    );
    assign state_vec[i]  = lane_out[i].state;
    assign change_vec[i] = lane_out[i].changed;
  end

  // Merge lanes into one result item.
  assign result.states = dtiq_pkg::LevelW'(state_vec);
  assign result.trig   = hold ? '0 : dtiq_pkg::LevelW'(change_vec);
  assign result.hold   = hold;

  dtiq_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (result),
    .can_push   (in_ready),
    .head_valid (out_valid),
    .head       (head),
    .pop_ready  (out_ready)
  );

  assign qualified_states = head.states;
  assign trigger_flags    = head.trig;
  assign holdoff_active   = head.hold;

endmodule

/* sv/dtiq_checker.sv */
`include "assert_macros.svh"

module dtiq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [dtiq_pkg::LevelW-1:0]     raw_levels,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [dtiq_pkg::LevelW-1:0]     qualified_states,
  input logic [dtiq_pkg::LevelW-1:0]     trigger_flags,
  input logic                            holdoff_active
);

  // States of the last delivered result.
  logic [dtiq_pkg::LevelW-1:0]     prev_states;
  // Whole result payload and the trigger flags it should carry.
  logic [2*dtiq_pkg::LevelW:0]     out_bits;
  logic [dtiq_pkg::LevelW-1:0]     trig_want;

  assign out_bits  = {qualified_states, trigger_flags, holdoff_active};
  assign trig_want = holdoff_active ? '0 : (qualified_states ^ prev_states);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_states <= '0;
    end else if (out_valid && out_ready) begin
      prev_states <= qualified_states;
    end
  end

  `DTIQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bits), "stalled result changed")
  `DTIQ_ASSERT(a_trig_match, out_valid, trigger_flags == trig_want, "trigger flags disagree")
  `DTIQ_ASSERT(a_full_shows, !in_ready, out_valid, "input stalled with no result pending")
  `DTIQ_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(raw_levels), "request dropped")

endmodule

bind dual_time_input_qualifier dtiq_checker u_dtiq_checker (.*);

/* sim/tb_dual_time_input_qualifier.sv */
`timescale 1ns / 100ps

module tb_dual_time_input_qualifier;
  import dtiq_pkg::*;

  // idle wait after the last result before a register write
  localparam int DRAIN_CYCLES    = 4;
  localparam int RAND_PHASES     = 8;
  localparam int TICKS_PER_PHASE = 112;

  // directed table: a row is either one tick request or one register write
  localparam bit ROW_TICK   = 1'b0;
  localparam bit ROW_CFG    = 1'b1;
  localparam bit FROM_PRED  = 1'b0;  // expectation comes from the predictor
  localparam bit FROM_TABLE = 1'b1;  // expectation typed into the row

  localparam result_t NO_RESULT = '0;

  typedef struct packed {
    logic                row_kind;
    cfg_reg_e            reg_sel;
    logic [CfgDataW-1:0] wdata;
    logic [LevelW-1:0]   raw;
    logic                exp_src;
    result_t             lit;
  } dir_row_t;

  localparam int DIR_ROWS = 30;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // reset config: on 20, off 20, active low, hold-off 30
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'hFF, FROM_TABLE, '{8'h00, 8'h00, 1'b1}},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'h00, FROM_TABLE, '{8'h00, 8'h00, 1'b1}},
    // one-tick thresholds, hold-off cleared by its write
    '{ROW_CFG,  REG_ON_TIME,    16'd1,     8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_CFG,  REG_OFF_TIME,   16'd1,     8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_CFG,  REG_HOLDOFF,    16'd0,     8'h00, FROM_PRED,  NO_RESULT},
    // count already at the lowered threshold: stuck until the level falls back
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'hFF, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'h00, FROM_TABLE, '{8'hFF, 8'hFF, 1'b0}},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'hFF, FROM_TABLE, '{8'h00, 8'hFF, 1'b0}},
    // zero on-time never turns on
    '{ROW_CFG,  REG_ON_TIME,    16'd0,     8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'h00, FROM_PRED,  NO_RESULT},
    // active high, zero off-time never turns off
    '{ROW_CFG,  REG_ACTIVE_LOW, 16'd0,     8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_CFG,  REG_ON_TIME,    16'd2,     8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_CFG,  REG_OFF_TIME,   16'd0,     8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'h55, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'h55, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'h00, FROM_PRED,  NO_RESULT},
    // extremes, long hold-off
    '{ROW_CFG,  REG_ON_TIME,    16'hFFFF,  8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_CFG,  REG_OFF_TIME,   16'hFFFF,  8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_CFG,  REG_HOLDOFF,    16'd255,   8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'hFF, FROM_PRED,  NO_RESULT},
    // short hold-off: a switch inside it has its trigger masked
    '{ROW_CFG,  REG_ON_TIME,    16'd1,     8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_CFG,  REG_HOLDOFF,    16'd3,     8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'hAA, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'hAA, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'hAA, FROM_PRED,  NO_RESULT},
    // off-time lowered below a running off count
    '{ROW_CFG,  REG_OFF_TIME,   16'd1,     8'h00, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'hFF, FROM_PRED,  NO_RESULT},
    '{ROW_TICK, REG_ON_TIME,    16'd0,     8'h00, FROM_PRED,  NO_RESULT}
  };

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;
  logic                in_valid   = 1'b0;
  logic [LevelW-1:0]   raw_levels = '0;
  logic                out_ready  = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [LevelW-1:0]   qualified_states;
  logic [LevelW-1:0]   trigger_flags;
  logic                holdoff_active;

  dual_time_input_qualifier u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .raw_levels       (raw_levels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .qualified_states (qualified_states),
    .trigger_flags    (trigger_flags),
    .holdoff_active   (holdoff_active)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop; a healthy run ends far earlier
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Qualifier predictor: own copy of the registers and per-channel counters.
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0]  on_thr;
  logic [TimeW-1:0]  off_thr;
  logic              low_active;
  logic [HoldW-1:0]  hold_cnt;
  logic              chan_on  [NumChannels];
  logic              last_on  [NumChannels];
  logic [CountW-1:0] on_cnt   [NumChannels];
  logic [CountW-1:0] off_cnt  [NumChannels];

  result_t pending_results [$];  // qualified results not yet seen at the output
  int      err_count = 0;
  int      src_idle_pct  = 0;    // chance per cycle that no request is offered
  int      sink_stall_pct = 0;   // chance per cycle that out_ready is low

  function automatic void note_reg_write(input cfg_reg_e sel, input logic [CfgDataW-1:0] val);
    case (sel)
      REG_ON_TIME:    on_thr     = val[TimeW-1:0];
      REG_OFF_TIME:   off_thr    = val[TimeW-1:0];
      REG_ACTIVE_LOW: low_active = val[0];
      REG_HOLDOFF:    hold_cnt   = val[HoldW-1:0];  // write reloads the counter
      default: ;
    endcase
  endfunction

  function automatic result_t qualify_tick(input logic [LevelW-1:0] raw);
    result_t r;
    logic    act;
    logic    held;
    r    = '0;
    held = (hold_cnt != '0);
    for (int i = 0; i < NumChannels; i++) begin
      act = low_active ? ~raw[i] : raw[i];
      if (!chan_on[i]) begin
        if (act) begin
          // a count at or above the threshold (incl. zero threshold) is frozen
          if (on_cnt[i] < on_thr) begin
            on_cnt[i] = on_cnt[i] + 1'b1;
            if (on_cnt[i] == on_thr) chan_on[i] = 1'b1;
          end
        end else begin
          on_cnt[i] = '0;
        end
      end else begin
        if (!act) begin
          if (off_cnt[i] < off_thr) begin
            off_cnt[i] = off_cnt[i] + 1'b1;
            if (off_cnt[i] == off_thr) chan_on[i] = 1'b0;
          end
        end else begin
          off_cnt[i] = '0;
        end
      end
      if (chan_on[i] != last_on[i]) begin
        last_on[i] = chan_on[i];
        if (chan_on[i]) off_cnt[i] = '0;
        else on_cnt[i] = '0;
        if (!held) r.trig[i] = 1'b1;
      end
      r.states[i] = chan_on[i];
    end
    if (held) hold_cnt = hold_cnt - 1'b1;
    r.hold = held;
    return r;
  endfunction

  function automatic logic [TimeW-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return TimeW'($urandom_range(0, 65535));
      default: return TimeW'($urandom_range(1, 6));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One register write; cfg_we drops for a cycle so back-to-back writes never
  // assign it twice in one step.
  task automatic write_reg(input cfg_reg_e sel, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    note_reg_write(sel, val);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Block is idle once every predicted result has come out.
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offer one tick request, hold it until accepted, then log its expectation.
  task automatic send_tick(input logic [LevelW-1:0] raw, input logic use_lit,
                           input result_t lit);
    result_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_levels <= raw;
    do @(posedge clk); while (!in_ready);
    pred = qualify_tick(raw);
    pending_results.push_back(use_lit ? lit : pred);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and out_ready pattern. Sampled values are the ones held
  // before the edge, so ordering against the DUT flops does not matter.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result states %h trig %h hold %b", $time,
                 qualified_states, trigger_flags, holdoff_active);
      end else begin
        want = pending_results.pop_front();
        if (qualified_states !== want.states) begin
          err_count++;
          $display("%0t: qualified_states expected %h actual %h", $time,
                   want.states, qualified_states);
        end
        if (trigger_flags !== want.trig) begin
          err_count++;
          $display("%0t: trigger_flags expected %h actual %h", $time,
                   want.trig, trigger_flags);
        end
        if (holdoff_active !== want.hold) begin
          err_count++;
          $display("%0t: holdoff_active expected %b actual %b", $time,
                   want.hold, holdoff_active);
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random phases with varied settings
  // and idle patterns. Random levels are mostly sticky so channels build runs
  // long enough to cross the thresholds; the rest is raw noise.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [LevelW-1:0] cur_raw;
    int                flip_div;
    on_thr     = TimeW'(OnTimeRst);
    off_thr    = TimeW'(OffTimeRst);
    low_active = 1'b1;
    hold_cnt   = HoldW'(HoldoffRst);
    for (int i = 0; i < NumChannels; i++) begin
      chan_on[i] = 1'b0;
      last_on[i] = 1'b0;
      on_cnt[i]  = '0;
      off_cnt[i] = '0;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no idling
    for (int k = 0; k < DIR_ROWS; k++) begin
      if (DIR_TAB[k].row_kind == ROW_CFG) begin
        in_valid <= 1'b0;
        wait_idle();
        write_reg(DIR_TAB[k].reg_sel, DIR_TAB[k].wdata);
      end else begin
        send_tick(DIR_TAB[k].raw, DIR_TAB[k].exp_src, DIR_TAB[k].lit);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      in_valid <= 1'b0;
      wait_idle();
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
        default: begin src_idle_pct = 22; sink_stall_pct = 22; end
      endcase
      // some registers are left alone so counts carry over a setting change
      if (p == 0 || $urandom_range(0, 3) != 0) write_reg(REG_ON_TIME, pick_threshold());
      if (p == 0 || $urandom_range(0, 3) != 0) write_reg(REG_OFF_TIME, pick_threshold());
      if (p == 0 || $urandom_range(0, 3) != 0)
        write_reg(REG_ACTIVE_LOW, CfgDataW'($urandom()));
      if (p == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       write_reg(REG_HOLDOFF, {8'($urandom()), 8'd0});
          1:       write_reg(REG_HOLDOFF, {8'($urandom()), 8'd255});
          default: write_reg(REG_HOLDOFF, {8'($urandom()), 8'($urandom_range(1, 40))});
        endcase
      end
      flip_div = $urandom_range(1, 12);
      cur_raw  = LevelW'($urandom());
      repeat (TICKS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 8) begin
          for (int b = 0; b < LevelW; b++)
            if ($urandom_range(0, flip_div - 1) == 0) cur_raw[b] = ~cur_raw[b];
        end else begin
          cur_raw = LevelW'($urandom());
        end
        send_tick(cur_raw, FROM_PRED, NO_RESULT);
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
